// File: hdl/sdsce_pkg.sv
// Shared types, constants and the CRC-7 byte step for the SD SPI command engine.
package sdsce_pkg;

	localparam logic       MODE_ISSUE      = 1'b0;
	localparam logic       MODE_RX         = 1'b1;

	localparam logic       CFG_POLL_LIMIT  = 1'b0;
	localparam logic       CFG_CLEAR_LIMIT = 1'b1;

	localparam logic [7:0] FILL_BYTE       = 8'hFF;
	localparam logic [7:0] START_BITS      = 8'h40;
	localparam logic [6:0] CRC_TAPS        = 7'h09;
	localparam logic [5:0] CMD_IF_COND     = 6'd8;
	localparam logic [5:0] CMD_READ_OCR    = 6'd58;

	localparam logic [7:0] POLL_LIMIT_RST  = 8'd8;
	localparam logic [3:0] CLEAR_LIMIT_RST = 4'd8;

	localparam int         QUEUE_DEPTH     = 2;

	// frame byte counter during an issue: fill, fill, five frame bytes, CRC
	localparam logic [2:0] SEQ_FIRST_FRAME = 3'd2;
	localparam logic [2:0] SEQ_LAST_FRAME  = 3'd6;
	localparam logic [2:0] SEQ_CRC_BYTE    = 3'd7;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_POLL,
		PH_CLEAR
	} phase_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_ISSUE
	} seq_t;

	typedef struct packed {
		logic        is_issue;
		logic        skip_clear;
		logic [7:0]  frame0;
		logic [31:0] arg;
		logic [7:0]  rx;
		logic        rx_ff;
	} q_entry_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       last_of_run;
		logic       finished;
		logic [7:0] r1_response;
		logic       timed_out;
	} result_t;

	function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
		logic [6:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ b[i];
			c  = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_TAPS;
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/sdsce_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
module sdsce_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [5:0]          cmd_index,
	input  logic [31:0]         cmd_argument,
	input  logic [7:0]          rx_byte,
	output logic                q_valid,
	output sdsce_pkg::q_entry_t q_entry,
	input  logic                q_pop
);
	import sdsce_pkg::*;

	q_entry_t   entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	q_entry_t   new_entry;

	assign in_stall = (count_q == 2'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_entry  = entry_q[rd_ptr_q];

	always_comb begin
		new_entry.is_issue   = (mode == MODE_ISSUE);
		new_entry.skip_clear = (cmd_index == CMD_IF_COND) || (cmd_index == CMD_READ_OCR);
		new_entry.frame0     = START_BITS | {2'b00, cmd_index};
		new_entry.arg        = cmd_argument;
		new_entry.rx         = rx_byte;
		new_entry.rx_ff      = (rx_byte == FILL_BYTE);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QUEUE_DEPTH))
		else $error("queue count over depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0)
		else $error("pop from empty queue");
`endif

endmodule

// File: hdl/sdsce_back.sv
// Back end: command sequencer, CRC-7, R1 polling and trailing clear, result register.
module sdsce_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sdsce_pkg::q_entry_t q_entry,
	output logic                q_pop,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sdsce_pkg::result_t  result
);
	import sdsce_pkg::*;

	seq_t        seq_q;
	seq_t        seq_d;
	logic [2:0]  cnt_q;
	logic [39:0] sh_q;
	logic [6:0]  crc_q;
	phase_t      phase_q;
	logic [7:0]  poll_cnt_q;
	logic [3:0]  clr_cnt_q;
	logic        skip_q;
	logic [7:0]  held_q;
	logic [7:0]  poll_lim_q;
	logic [3:0]  clr_lim_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        out_free;
	logic        load;
	result_t     res;
	logic [7:0]  poll_lim;
	logic [3:0]  clr_lim;
	logic [7:0]  poll_inc;
	logic [3:0]  clr_inc;
	logic        poll_hit;
	logic        poll_fin;
	logic        clr_fin;
	result_t     go_on;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	always_comb begin
		poll_lim = (poll_lim_q == 8'd0) ? 8'd1 : poll_lim_q;
		clr_lim  = (clr_lim_q == 4'd0) ? 4'd1 : clr_lim_q;
		poll_inc = (poll_cnt_q != 8'hFF) ? poll_cnt_q + 8'd1 : poll_cnt_q;
		clr_inc  = clr_cnt_q + 4'd1;
		poll_hit = !q_entry.rx[7] || (poll_inc >= poll_lim);
		poll_fin = poll_hit && (skip_q || q_entry.rx_ff);
		clr_fin  = q_entry.rx_ff || (clr_inc >= clr_lim) || (clr_inc == 4'd0);
		go_on    = '{tx_byte: FILL_BYTE, tx_valid: 1'b1, last_of_run: 1'b1,
			finished: 1'b0, r1_response: 8'd0, timed_out: 1'b0};
	end

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IDLE: begin
				if (q_valid && out_free && q_entry.is_issue) begin
					seq_d = SEQ_ISSUE;
				end
			end
			SEQ_ISSUE: begin
				if (out_free && cnt_q == SEQ_CRC_BYTE) begin
					seq_d = SEQ_IDLE;
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load  = 1'b0;
		res   = '{tx_byte: FILL_BYTE, tx_valid: 1'b1, last_of_run: 1'b0,
			finished: 1'b0, r1_response: 8'd0, timed_out: 1'b0};
		case (seq_q)
			SEQ_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_entry.is_issue) begin
						load = 1'b1;
					end else begin
						case (phase_q)
							PH_POLL: begin
								load = 1'b1;
								res  = go_on;
								if (poll_fin) begin
									res = '{tx_byte: FILL_BYTE, tx_valid: 1'b0,
										last_of_run: 1'b1, finished: 1'b1,
										r1_response: q_entry.rx,
										timed_out: q_entry.rx[7]};
								end
							end
							PH_CLEAR: begin
								load = 1'b1;
								res  = go_on;
								if (clr_fin) begin
									res = '{tx_byte: FILL_BYTE, tx_valid: 1'b0,
										last_of_run: 1'b1, finished: 1'b1,
										r1_response: held_q, timed_out: held_q[7]};
								end
							end
							default: load = 1'b0;
						endcase
					end
				end
			end
			SEQ_ISSUE: begin
				if (out_free) begin
					load = 1'b1;
					if (cnt_q == SEQ_CRC_BYTE) begin
						res.tx_byte     = {crc_q, 1'b1};
						res.last_of_run = 1'b1;
					end else if (cnt_q >= SEQ_FIRST_FRAME) begin
						res.tx_byte = sh_q[39:32];
					end
				end
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.is_issue) begin
			sh_q  <= {q_entry.frame0, q_entry.arg};
			crc_q <= 7'd0;
		end else if (seq_q == SEQ_ISSUE && out_free && cnt_q >= SEQ_FIRST_FRAME
				&& cnt_q <= SEQ_LAST_FRAME) begin
			sh_q  <= {sh_q[31:0], 8'd0};
			crc_q <= crc7_byte(crc_q, sh_q[39:32]);
		end
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_IDLE;
			cnt_q       <= 3'd0;
			phase_q     <= PH_IDLE;
			poll_cnt_q  <= 8'd0;
			clr_cnt_q   <= 4'd0;
			skip_q      <= 1'b0;
			held_q      <= FILL_BYTE;
			poll_lim_q  <= POLL_LIMIT_RST;
			clr_lim_q   <= CLEAR_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLL_LIMIT:  poll_lim_q <= cfg_data;
					CFG_CLEAR_LIMIT: clr_lim_q  <= cfg_data[3:0];
					default:         poll_lim_q <= poll_lim_q;
				endcase
			end
			if (seq_q == SEQ_ISSUE && out_free) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (q_pop) begin
				if (q_entry.is_issue) begin
					cnt_q      <= 3'd1;
					phase_q    <= PH_POLL;
					poll_cnt_q <= 8'd0;
					clr_cnt_q  <= 4'd0;
					skip_q     <= q_entry.skip_clear;
					held_q     <= FILL_BYTE;
				end else begin
					case (phase_q)
						PH_POLL: begin
							held_q     <= q_entry.rx;
							poll_cnt_q <= poll_inc;
							if (poll_hit) begin
								if (poll_fin) begin
									phase_q <= PH_IDLE;
								end else begin
									phase_q   <= PH_CLEAR;
									clr_cnt_q <= 4'd0;
								end
							end
						end
						PH_CLEAR: begin
							clr_cnt_q <= clr_inc;
							if (clr_fin) begin
								phase_q <= PH_IDLE;
							end
						end
						default: phase_q <= PH_IDLE;
					endcase
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_issue_polls: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_ISSUE |-> phase_q == PH_POLL)
		else $error("issue sequence outside polling phase");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.finished |-> phase_q == PH_IDLE)
		else $error("finished result while exchange still open");
	a_crc_ends_issue: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_ISSUE && out_free && cnt_q == SEQ_CRC_BYTE
			|=> seq_q == SEQ_IDLE && out_valid_q && out_q.last_of_run)
		else $error("CRC byte did not close the issue sequence");
`endif

endmodule

// File: hdl/sd_spi_command_engine_unit.sv
// Top level of the SD-card SPI-mode command engine.
//
// Input channel (in_valid / in_stall): mode 0 issues a command (cmd_index,
// cmd_argument); mode 1 hands over one byte clocked in from the card (rx_byte).
// Output channel (out_valid / out_stall): one byte request per result, with
// tx_byte, tx_valid, last_of_run, finished, r1_response and timed_out.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 response poll limit, 1 trailing clear limit); write only while idle.
// An issue yields eight results at one per cycle while out_stall is low: two fill bytes, the frame
// and the CRC-7 byte, which is built one frame byte per cycle as it goes out.
// A received byte yields one result, none while no exchange runs.
// The first result of a request is registered once the back end takes it from
// the queue. A two-entry queue parts intake from the sequencer, so input
// is taken while results wait. A stalled result holds; the queue fills and
// then raises in_stall. Reset clears the queue, the sequencer and the exchange
// state and loads both limits with 8.
module sd_spi_command_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [5:0]  cmd_index,
	input  logic [31:0] cmd_argument,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic        last_of_run,
	output logic        finished,
	output logic [7:0]  r1_response,
	output logic        timed_out,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import sdsce_pkg::*;

	logic     q_valid;
	q_entry_t q_entry;
	logic     q_pop;
	result_t  result;

	sdsce_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.cmd_index    (cmd_index),
		.cmd_argument (cmd_argument),
		.rx_byte      (rx_byte),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop)
	);

	sdsce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign tx_byte     = result.tx_byte;
	assign tx_valid    = result.tx_valid;
	assign last_of_run = result.last_of_run;
	assign finished    = result.finished;
	assign r1_response = result.r1_response;
	assign timed_out   = result.timed_out;

endmodule

// File: tb/testbench.sv
// Self-checking bench for the SD SPI command engine: directed table, then random exchanges.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sdsce_pkg::*;

	localparam int SETTLE_CYCLES = 20;
	localparam int END_WAIT      = 20000;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int PHASES        = 6;
	localparam int PHASE_REQS    = 36;
	localparam int MAX_LINES     = 40;

	localparam logic [7:0] POLL_SET  [PHASES] = '{8'd8, 8'd1, 8'd255, 8'd0, 8'd4, 8'd0};
	localparam logic [7:0] CLEAR_SET [PHASES] = '{8'd8, 8'd1, 8'h0F, 8'hF0, 8'h13, 8'd0};

	typedef enum logic [1:0] {
		ROW_PRED,
		ROW_TYPED,
		ROW_NONE,
		ROW_CFG
	} row_kind_t;

	// for ROW_CFG rows m carries the register index and rx the write data
	typedef struct packed {
		row_kind_t   kind;
		logic        m;
		logic [5:0]  idx;
		logic [31:0] arg;
		logic [7:0]  rx;
		result_t     want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [5:0]  cmd_index;
	logic [31:0] cmd_argument;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  tx_byte;
	logic        tx_valid;
	logic        last_of_run;
	logic        finished;
	logic [7:0]  r1_response;
	logic        timed_out;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	// predictor copy of the engine
	logic [7:0]  poll_limit  = POLL_LIMIT_RST;
	logic [3:0]  clear_limit = CLEAR_LIMIT_RST;
	phase_t      ph          = PH_IDLE;
	logic [7:0]  polls       = '0;
	logic [3:0]  clears      = '0;
	logic        skip        = 1'b0;
	logic [7:0]  held        = FILL_BYTE;
	result_t     step_bytes [8];

	result_t     due_bytes [$];

	int errors      = 0;
	int n_reqs      = 0;
	int useful_reqs = 0;
	int n_issues    = 0;
	int n_checked   = 0;
	int n_finishes  = 0;
	int n_timeouts  = 0;
	int n_writes    = 0;
	int burst_left  = 0;

	sd_spi_command_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.cmd_index   (cmd_index),
		.cmd_argument(cmd_argument),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tx_byte     (tx_byte),
		.tx_valid    (tx_valid),
		.last_of_run (last_of_run),
		.finished    (finished),
		.r1_response (r1_response),
		.timed_out   (timed_out),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("sd_spi_command_engine_unit test failed");
		$finish;
	end

	task automatic flag(input string msg);
		if (errors < MAX_LINES) begin
			$display("ERROR %0t: %s", $realtime, msg);
		end
		errors++;
	endtask

	function automatic result_t cont_byte();
		result_t b;
		b             = '0;
		b.tx_byte     = FILL_BYTE;
		b.tx_valid    = 1'b1;
		b.last_of_run = 1'b1;
		return b;
	endfunction

	function automatic result_t done_byte(input logic [7:0] r1, input logic to);
		result_t b;
		b             = '0;
		b.tx_byte     = FILL_BYTE;
		b.last_of_run = 1'b1;
		b.finished    = 1'b1;
		b.r1_response = r1;
		b.timed_out   = to;
		return b;
	endfunction

	function automatic logic [6:0] frame_crc(input logic [39:0] bits);
		logic [6:0] c;
		logic       fb;
		c = '0;
		for (int i = 39; i >= 0; i--) begin
			fb = c[6] ^ bits[i];
			c  = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_TAPS;
			end
		end
		return c;
	endfunction

	// works out the bytes one request causes, fills step_bytes, returns the count
	function automatic int bytes_for_request(input logic m, input logic [5:0] idx,
			input logic [31:0] arg, input logic [7:0] rx);
		logic [39:0] head;
		logic [47:0] cmd_frame;
		logic [7:0]  lim;
		logic [3:0]  clim;
		if (m == MODE_ISSUE) begin
			head      = {START_BITS | {2'b00, idx}, arg};
			cmd_frame = {head, frame_crc(head), 1'b1};
			for (int k = 0; k < 8; k++) begin
				step_bytes[k]             = '0;
				step_bytes[k].tx_valid    = 1'b1;
				step_bytes[k].last_of_run = (k == 7);
				step_bytes[k].tx_byte     = (k < 2) ? FILL_BYTE : cmd_frame[47 - 8 * (k - 2) -: 8];
			end
			ph     = PH_POLL;
			polls  = '0;
			clears = '0;
			skip   = (idx == CMD_IF_COND) || (idx == CMD_READ_OCR);
			held   = FILL_BYTE;
			return 8;
		end
		case (ph)
			PH_POLL: begin
				lim  = (poll_limit == 0) ? 8'd1 : poll_limit;
				held = rx;
				if (polls != 8'hFF) begin
					polls++;
				end
				if (!rx[7] || polls >= lim) begin
					if (skip || rx == FILL_BYTE) begin
						ph            = PH_IDLE;
						step_bytes[0] = done_byte(held, held[7]);
						return 1;
					end
					ph     = PH_CLEAR;
					clears = '0;
				end
				step_bytes[0] = cont_byte();
				return 1;
			end
			PH_CLEAR: begin
				clim   = (clear_limit == 0) ? 4'd1 : clear_limit;
				clears = clears + 4'd1;
				if (rx == FILL_BYTE || clears >= clim || clears == 0) begin
					ph            = PH_IDLE;
					step_bytes[0] = done_byte(held, held[7]);
					return 1;
				end
				step_bytes[0] = cont_byte();
				return 1;
			end
			default: begin
				ph = PH_IDLE;
				return 0;
			end
		endcase
	endfunction

	function automatic row_t issue_row(input logic [5:0] idx, input logic [31:0] arg);
		row_t r;
		r      = '0;
		r.kind = ROW_PRED;
		r.m    = MODE_ISSUE;
		r.idx  = idx;
		r.arg  = arg;
		return r;
	endfunction

	function automatic row_t rx_row(input row_kind_t kind, input logic [7:0] rx,
			input result_t want);
		row_t r;
		r      = '0;
		r.kind = kind;
		r.m    = MODE_RX;
		r.rx   = rx;
		r.want = want;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic sel, input logic [7:0] data);
		row_t r;
		r      = '0;
		r.kind = ROW_CFG;
		r.m    = sel;
		r.rx   = data;
		return r;
	endfunction

	// result side
	always @(posedge clk) begin : result_check
		result_t w;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			n_checked++;
			if (finished === 1'b1) begin
				n_finishes++;
			end
			if (finished === 1'b1 && timed_out === 1'b1) begin
				n_timeouts++;
			end
			if (due_bytes.size() == 0) begin
				flag($sformatf("unexpected result, tx_byte %02h", tx_byte));
			end else begin
				w = due_bytes.pop_front();
				if (tx_byte !== w.tx_byte) begin
					flag($sformatf("tx_byte %02h, want %02h", tx_byte, w.tx_byte));
				end
				if (tx_valid !== w.tx_valid) begin
					flag($sformatf("tx_valid %b, want %b", tx_valid, w.tx_valid));
				end
				if (last_of_run !== w.last_of_run) begin
					flag($sformatf("last_of_run %b, want %b", last_of_run, w.last_of_run));
				end
				if (finished !== w.finished) begin
					flag($sformatf("finished %b, want %b", finished, w.finished));
				end
				if (r1_response !== w.r1_response) begin
					flag($sformatf("r1_response %02h, want %02h", r1_response, w.r1_response));
				end
				if (timed_out !== w.timed_out) begin
					flag($sformatf("timed_out %b, want %b", timed_out, w.timed_out));
				end
			end
		end
	end

	// receiver back-pressure: free stretches, light stalls, heavy stalls
	initial begin : stall_pattern
		int style;
		int len;
		out_stall = 1'b0;
		forever begin
			style = $urandom_range(0, 2);
			len   = $urandom_range(20, 60);
			repeat (len) begin
				@(negedge clk);
				case (style)
					0: begin
						out_stall = 1'b0;
					end
					1: begin
						out_stall = ($urandom_range(0, 9) < 3);
					end
					default: begin
						out_stall = ($urandom_range(0, 3) != 0);
					end
				endcase
			end
		end
	end

	task automatic send_req(input logic m, input logic [5:0] idx, input logic [31:0] arg,
			input logic [7:0] rx, input row_kind_t kind, input result_t want);
		int cnt;
		mode         = m;
		cmd_index    = idx;
		cmd_argument = arg;
		rx_byte      = rx;
		in_valid     = 1'b1;
		do @(posedge clk); while (in_stall);
		cnt = bytes_for_request(m, idx, arg, rx);
		if (kind == ROW_TYPED) begin
			due_bytes.push_back(want);
		end else if (kind == ROW_PRED) begin
			for (int i = 0; i < cnt; i++) begin
				due_bytes.push_back(step_bytes[i]);
			end
		end
		n_reqs++;
		if (cnt != 0) begin
			useful_reqs++;
		end
		if (m == MODE_ISSUE) begin
			n_issues++;
		end
		@(negedge clk);
	endtask

	task automatic idle_after();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (due_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [7:0] data);
		cfg_index = sel;
		cfg_data  = data;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (sel == CFG_POLL_LIMIT) begin
			poll_limit = data;
		end else begin
			clear_limit = data[3:0];
		end
		n_writes++;
	endtask

	initial begin : stimulus
		row_t        plan [$];
		row_t        r;
		logic        m;
		logic [5:0]  idx;
		logic [31:0] arg;
		logic [7:0]  rx;
		int          start;
		int          n;
		bit          paused;

		in_valid     = 1'b0;
		mode         = MODE_ISSUE;
		cmd_index    = '0;
		cmd_argument = '0;
		rx_byte      = '0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_POLL_LIMIT;
		cfg_data     = '0;
		arst_n       = 1'b0;

		// reset limits: plain exchange, skipped clear, drop while busy
		plan.push_back(rx_row(ROW_NONE, 8'h00, '0));
		plan.push_back(issue_row(6'd0, 32'h0000_0000));
		plan.push_back(rx_row(ROW_TYPED, 8'hFF, cont_byte()));
		plan.push_back(rx_row(ROW_PRED, 8'h01, '0));
		plan.push_back(rx_row(ROW_PRED, 8'h55, '0));
		plan.push_back(rx_row(ROW_TYPED, 8'hFF, done_byte(8'h01, 1'b0)));
		plan.push_back(issue_row(CMD_IF_COND, 32'h0000_01AA));
		plan.push_back(rx_row(ROW_TYPED, 8'h01, done_byte(8'h01, 1'b0)));
		plan.push_back(issue_row(CMD_READ_OCR, 32'hFFFF_FFFF));
		plan.push_back(rx_row(ROW_TYPED, 8'h00, done_byte(8'h00, 1'b0)));
		plan.push_back(issue_row(6'd63, 32'hFFFF_FFFF));
		plan.push_back(issue_row(6'd17, 32'h1234_5678));
		plan.push_back(rx_row(ROW_PRED, 8'h00, '0));
		plan.push_back(rx_row(ROW_TYPED, 8'hFF, done_byte(8'h00, 1'b0)));
		plan.push_back(rx_row(ROW_NONE, 8'hAB, '0));
		// short limits: timeout then clear, timeout on an all-ones byte
		plan.push_back(cfg_row(CFG_POLL_LIMIT, 8'd2));
		plan.push_back(cfg_row(CFG_CLEAR_LIMIT, 8'd3));
		plan.push_back(issue_row(6'd55, 32'hA5A5_A5A5));
		plan.push_back(rx_row(ROW_PRED, 8'hFE, '0));
		plan.push_back(rx_row(ROW_TYPED, 8'hFE, cont_byte()));
		plan.push_back(rx_row(ROW_PRED, 8'h80, '0));
		plan.push_back(rx_row(ROW_PRED, 8'h81, '0));
		plan.push_back(rx_row(ROW_TYPED, 8'h82, done_byte(8'hFE, 1'b1)));
		plan.push_back(issue_row(6'd1, 32'h0000_0000));
		plan.push_back(rx_row(ROW_PRED, 8'hC0, '0));
		plan.push_back(rx_row(ROW_TYPED, 8'hFF, done_byte(8'hFF, 1'b1)));
		// zero limits behave as one
		plan.push_back(cfg_row(CFG_POLL_LIMIT, 8'd0));
		plan.push_back(cfg_row(CFG_CLEAR_LIMIT, 8'd0));
		plan.push_back(issue_row(6'd42, 32'h8000_0001));
		plan.push_back(rx_row(ROW_TYPED, 8'h9F, cont_byte()));
		plan.push_back(rx_row(ROW_TYPED, 8'h00, done_byte(8'h9F, 1'b1)));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			r = plan[k];
			if (r.kind == ROW_CFG) begin
				wait_idle();
				write_reg(r.m, r.rx);
			end else begin
				send_req(r.m, r.idx, r.arg, r.rx, r.kind, r.want);
				idle_after();
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == PHASES - 1) begin
				write_reg(CFG_POLL_LIMIT, 8'($urandom_range(1, 255)));
				write_reg(CFG_CLEAR_LIMIT, 8'($urandom_range(0, 255)));
			end else begin
				write_reg(CFG_POLL_LIMIT, POLL_SET[p]);
				write_reg(CFG_CLEAR_LIMIT, CLEAR_SET[p]);
			end
			start  = useful_reqs;
			paused = 1'b0;
			while (useful_reqs - start < PHASE_REQS) begin
				if (!paused && useful_reqs - start >= PHASE_REQS / 2) begin
					// hold off until the engine has caught up
					paused   = 1'b1;
					in_valid = 1'b0;
					while (due_bytes.size() != 0) @(negedge clk);
				end
				if (ph == PH_IDLE) begin
					m = ($urandom_range(0, 9) < 8) ? MODE_ISSUE : MODE_RX;
				end else begin
					m = ($urandom_range(0, 19) == 0) ? MODE_ISSUE : MODE_RX;
				end
				case ($urandom_range(0, 9))
					0: idx = CMD_IF_COND;
					1: idx = CMD_READ_OCR;
					default: idx = 6'($urandom_range(0, 63));
				endcase
				arg = $urandom;
				n   = $urandom_range(0, 9);
				rx  = 8'($urandom_range(0, 255));
				if (ph == PH_POLL) begin
					if (n < 3) begin
						rx[7] = 1'b0;
					end else if (n == 3) begin
						rx = FILL_BYTE;
					end else begin
						rx[7] = 1'b1;
					end
				end else if (ph == PH_CLEAR && n < 3) begin
					rx = FILL_BYTE;
				end
				send_req(m, idx, arg, rx, ROW_PRED, '0);
				idle_after();
			end
		end

		in_valid = 1'b0;
		for (n = 0; n < END_WAIT && due_bytes.size() != 0; n++) @(negedge clk);
		if (due_bytes.size() != 0) begin
			flag($sformatf("%0d expected results never arrived", due_bytes.size()));
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d requests (%0d issues), %0d register writes over %0d settings.",
			n_reqs, n_issues, n_writes, PHASES + 3);
		$display("Checked %0d results: %0d exchanges finished, %0d of them timed out; %0d errors.",
			n_checked, n_finishes, n_timeouts, errors);
		if (errors == 0) begin
			$display("sd_spi_command_engine_unit test passed");
		end else begin
			$display("sd_spi_command_engine_unit test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/sdsce_pkg.sv
hdl/sdsce_front.sv
hdl/sdsce_back.sv
hdl/sd_spi_command_engine_unit.sv
tb/testbench.sv
